/* hw/rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Result kinds and the job record that travels from the decode front end
// through the job queue to the result serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // result kinds as seen on rsp_tuser
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // one decoded input byte worth of results (one to four items)
   typedef struct packed {
      logic [1:0]      kind;     // KIND_DATA for all bytes, else a single status item
      logic [1:0]      last_idx; // number of items minus one
      logic [3:0][7:0] bytes;    // bytes[0] goes out first
   } job_type;

endpackage

/* hw/rtl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front: decode front end
// Holds the string parser state, classifies each accepted byte and builds
// a job holding the UTF-8 bytes or the status item it causes.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,      // byte transaction taken this cycle
   input  logic [7:0]       byte_value,
   input  logic             end_of_input,
   output logic             job_push,
   output jsu_pkg::job_type job_data
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_STR  = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX1 = 3'd3,
      MODE_BS2  = 3'd4,
      MODE_U2   = 3'd5,
      MODE_HEX2 = 3'd6
   } mode_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;

   mode_type    mode_ff, mode_in;
   logic [1:0]  digit_ff, digit_in;
   logic [15:0] accum_ff, accum_in;
   logic [9:0]  high_ff, high_in;

   logic [4:0]  hex_dig;
   logic [15:0] unit;
   logic [20:0] pair_cp;
   logic        has_result;
   jsu_pkg::job_type job;

   // hex digit value, bit 4 set when the byte is a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   // UTF-8 form of a scalar value
   function automatic jsu_pkg::job_type utf8(input logic [20:0] cp);
      jsu_pkg::job_type j;
      j = '0;
      j.kind = jsu_pkg::KIND_DATA;
      if (cp <= 21'h7F) begin
         j.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         j.last_idx = 2'd1;
         j.bytes[0] = {3'b110, cp[10:6]};
         j.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         j.last_idx = 2'd2;
         j.bytes[0] = {4'b1110, cp[15:12]};
         j.bytes[1] = {2'b10, cp[11:6]};
         j.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         j.last_idx = 2'd3;
         j.bytes[0] = {5'b11110, cp[20:18]};
         j.bytes[1] = {2'b10, cp[17:12]};
         j.bytes[2] = {2'b10, cp[11:6]};
         j.bytes[3] = {2'b10, cp[5:0]};
      end
      return j;
   endfunction

   function automatic jsu_pkg::job_type single(input logic [1:0] k, input logic [7:0] b);
      jsu_pkg::job_type j;
      j = '0;
      j.kind     = k;
      j.bytes[0] = b;
      return j;
   endfunction

   assign hex_dig = hex_val(byte_value);
   assign unit    = {accum_ff[11:0], hex_dig[3:0]};
   assign pair_cp = 21'h10000 + {1'b0, high_ff, unit[9:0]};

   // next state and job for the current byte
   always_comb begin
      mode_in    = mode_ff;
      digit_in   = digit_ff;
      accum_in   = accum_ff;
      high_in    = high_ff;
      has_result = 1'b0;
      job        = '0;
      if (end_of_input) begin
         has_result = 1'b1;
         job        = single(jsu_pkg::KIND_ERR, 8'd0);
      end else begin
         unique case (mode_ff)
            MODE_STR: begin
               if (byte_value == CH_QUOTE) begin
                  has_result = 1'b1;
                  job        = single(jsu_pkg::KIND_DONE, 8'd0);
               end else if (byte_value == CH_BSL) begin
                  mode_in = MODE_ESC;
               end else begin
                  has_result = 1'b1;
                  job        = single(jsu_pkg::KIND_DATA, byte_value);
               end
            end
            MODE_ESC: begin
               has_result = 1'b1;
               mode_in    = MODE_STR;
               case (byte_value)
                  8'h22, 8'h5C, 8'h2F: job = single(jsu_pkg::KIND_DATA, byte_value);
                  8'h62: job = single(jsu_pkg::KIND_DATA, 8'h08);
                  8'h66: job = single(jsu_pkg::KIND_DATA, 8'h0C);
                  8'h6E: job = single(jsu_pkg::KIND_DATA, 8'h0A);
                  8'h72: job = single(jsu_pkg::KIND_DATA, 8'h0D);
                  8'h74: job = single(jsu_pkg::KIND_DATA, 8'h09);
                  CH_U: begin
                     has_result = 1'b0;
                     mode_in    = MODE_HEX1;
                     digit_in   = 2'd0;
                     accum_in   = 16'd0;
                  end
                  default: job = single(jsu_pkg::KIND_ERR, 8'd0);
               endcase
            end
            MODE_HEX1, MODE_HEX2: begin
               if (!hex_dig[4]) begin
                  has_result = 1'b1;
                  job        = single(jsu_pkg::KIND_ERR, 8'd0);
               end else if (digit_ff != 2'd3) begin
                  digit_in = digit_ff + 2'd1;
                  accum_in = unit;
               end else begin
                  digit_in = 2'd0;
                  accum_in = 16'd0;
                  if (mode_ff == MODE_HEX1) begin
                     if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                        high_in = unit[9:0];
                        mode_in = MODE_BS2;
                     end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                        has_result = 1'b1;
                        job        = single(jsu_pkg::KIND_ERR, 8'd0);
                     end else begin
                        has_result = 1'b1;
                        mode_in    = MODE_STR;
                        job        = utf8({5'd0, unit});
                     end
                  end else begin
                     has_result = 1'b1;
                     if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                        job = single(jsu_pkg::KIND_ERR, 8'd0);
                     end else begin
                        high_in = 10'd0;
                        mode_in = MODE_STR;
                        job     = utf8(pair_cp);
                     end
                  end
               end
            end
            MODE_BS2: begin
               if (byte_value == CH_BSL) begin
                  mode_in = MODE_U2;
               end else begin
                  has_result = 1'b1;
                  job        = single(jsu_pkg::KIND_ERR, 8'd0);
               end
            end
            MODE_U2: begin
               if (byte_value == CH_U) begin
                  mode_in  = MODE_HEX2;
                  digit_in = 2'd0;
                  accum_in = 16'd0;
               end else begin
                  has_result = 1'b1;
                  job        = single(jsu_pkg::KIND_ERR, 8'd0);
               end
            end
            default: begin
               // idle: skip whitespace, wait for the opening quote
               if (byte_value == 8'h20 || (byte_value >= 8'h09 && byte_value <= 8'h0D)) begin
                  has_result = 1'b0;
               end else if (byte_value == CH_QUOTE) begin
                  mode_in  = MODE_STR;
                  digit_in = 2'd0;
                  accum_in = 16'd0;
                  high_in  = 10'd0;
               end else begin
                  has_result = 1'b1;
                  job        = single(jsu_pkg::KIND_ERR, 8'd0);
               end
            end
         endcase
      end
      // done and error both drop back to idle with cleared scratch state
      if (has_result && job.kind != jsu_pkg::KIND_DATA) begin
         mode_in  = MODE_IDLE;
         digit_in = 2'd0;
         accum_in = 16'd0;
         high_in  = 10'd0;
      end
   end

   assign job_push = accept && has_result;
   assign job_data = job;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         digit_ff <= 2'd0;
         accum_ff <= 16'd0;
         high_ff  <= 10'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         accum_ff <= accum_in;
         high_ff  <= high_in;
      end
   end

endmodule

/* hw/rtl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue: job queue
// Small first-in first-out buffer of jobs between front end and serializer.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jsu_pkg::job_type head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   jsu_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* hw/rtl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Takes one job at a time from the queue and sends its items out one per
// cycle while rsp_tready is high, marking the final item of each job.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::job_type head_data,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic             busy_ff, busy_in;
   jsu_pkg::job_type cur_ff;
   logic [1:0]       idx_ff, idx_in;
   logic             at_last;
   logic             sent;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign sent    = busy_ff && rsp_tready;
   assign pop     = head_valid && (!busy_ff || (sent && at_last));

   // item index and job load
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (sent && at_last) begin
         busy_in = 1'b0;
      end else if (sent) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head_data;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = cur_ff.bytes[idx_ff];
   assign rsp_tuser  = cur_ff.kind;
   assign rsp_tlast  = at_last;

endmodule

/* hw/rtl/json_string_unescape_utf8_core.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core: JSON string literal unescaper to UTF-8
// Decodes raw, simple-escape and \uXXXX bytes of one string literal into
// UTF-8 data items, plus a done or error status item.
//
//  channel | dir | tdata          | tuser            | tlast
//  req     | in  | byte_value [7:0] | end_of_input [0] | -
//  rsp     | out | out_byte [7:0]   | kind [1:0]       | last
//
// One input byte is accepted per cycle while the job queue has room.
// Each byte that causes results puts one job of one to four items in the
// queue; the serializer sends one item per cycle while rsp_tready is high.
// Reset clears the parser state, queue pointers and output valid.
// A stalled output fills the queue (QUEUE_DEPTH jobs) before req_tready drops.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic [0:0] req_tuser,   // [0] end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   logic             accept;
   logic             job_push;
   jsu_pkg::job_type job_data;
   logic             q_full;
   logic             q_pop;
   logic             q_valid;
   jsu_pkg::job_type q_head;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_value   (req_tdata),
      .end_of_input (req_tuser[0]),
      .job_push     (job_push),
      .job_data     (job_data)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hw/rtl/jsu_checker.sv */
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks of the unescaper
// Watches the result channel for reset behavior, stalls, status items, result kinds and multi-byte sequences.
// ----------------------------------------------------------------------------
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // done and error are single items with a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != jsu_pkg::KIND_DATA |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("status item malformed");

   // only defined kinds appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == jsu_pkg::KIND_DATA || rsp_tuser == jsu_pkg::KIND_DONE ||
                     rsp_tuser == jsu_pkg::KIND_ERR)
      else $error("undefined result kind");

   // a data item that continues a sequence follows a non-last data item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == jsu_pkg::KIND_DATA)
      else $error("multi-byte sequence broken");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
